[rtl/core/qrm_pkg.sv]
// Package with shared widths and defaults for the quaternion to rotation matrix core.
package qrm_pkg;

  localparam int unsigned FRAC_BITS_DEF = 30;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned SCALAR_W      = 31;

  typedef logic signed [DATA_W-1:0]   data_t;
  typedef logic        [SCALAR_W-1:0] scalar_t;

endpackage

[rtl/core/qrm_if.sv]
// Valid/ready channel interfaces for quaternion input and matrix output transactions.
interface qrm_in_if;
  import qrm_pkg::*;

  logic  valid;
  logic  ready;
  data_t vec_x;
  data_t vec_y;
  data_t vec_z;

  modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
  modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

interface qrm_out_if;
  import qrm_pkg::*;

  logic    valid;
  logic    ready;
  data_t   row0_col0;
  data_t   row0_col1;
  data_t   row0_col2;
  data_t   row1_col0;
  data_t   row1_col1;
  data_t   row1_col2;
  data_t   row2_col0;
  data_t   row2_col1;
  data_t   row2_col2;
  scalar_t scalar_part;
  logic    norm_invalid;

  modport source (
    output valid, output row0_col0, output row0_col1, output row0_col2,
    output row1_col0, output row1_col1, output row1_col2,
    output row2_col0, output row2_col1, output row2_col2,
    output scalar_part, output norm_invalid, input ready
  );
  modport sink (
    input valid, input row0_col0, input row0_col1, input row0_col2,
    input row1_col0, input row1_col1, input row1_col2,
    input row2_col0, input row2_col1, input row2_col2,
    input scalar_part, input norm_invalid, output ready
  );
endinterface

[rtl/core/quaternion_to_rotation_matrix_core.sv]
// Top level: pipelined quaternion vector part to direction cosine matrix converter.
//
// Input transactions carry the vector part (vec_x, vec_y, vec_z) of an attitude
// quaternion with FRAC_BITS fraction bits. Each one yields exactly one output
// transaction with the nine matrix elements, rounded and saturated, the rebuilt
// scalar part and a flag that is set when the sum of squares exceeds one.
// A transaction is taken at a rising edge where valid and ready are both high.
// Throughput is one transaction per cycle while the receiver does not stall. The
// square root resolves one root bit per pipeline stage, with the multiply, add
// and rounding stages around it.
// The whole pipeline advances together; when the receiver stalls with a result
// pending, input ready drops and every stage holds its contents.
// Reset clears all stage valid bits; the pipeline is empty afterward.
module quaternion_to_rotation_matrix_core #(
  parameter int unsigned FRAC_BITS = qrm_pkg::FRAC_BITS_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  qrm_in_if.sink    in_i,
  qrm_out_if.source out_o
);
  import qrm_pkg::*;

  localparam int unsigned ROOT_W = FRAC_BITS + 1;
  localparam int unsigned RAD_W  = 2 * FRAC_BITS + 1;
  localparam int unsigned TW     = RAD_W + 2;
  localparam int unsigned PW     = 64;
  localparam int unsigned SW     = 66;

  localparam logic [PW-1:0]        ONE  = PW'(1) << (2 * FRAC_BITS);
  localparam logic signed [SW-1:0] MAXV = 66'sd2147483647;
  localparam logic signed [SW-1:0] MINV = -66'sd2147483648;

  function automatic data_t round_sat(input logic signed [SW-1:0] s, input int unsigned sh);
    logic signed [SW-1:0] t;
    t = s + (SW'(1) <<< (sh - 1));
    t = t >>> sh;
    if (t > MAXV) begin
      return data_t'(MAXV);
    end else if (t < MINV) begin
      return data_t'(MINV);
    end
    return data_t'(t);
  endfunction

  logic adv;
  logic out_v_q;

  assign adv        = !out_v_q || out_o.ready;
  assign in_i.ready = adv;

  // Stage 0: input registers.
  logic  s0_v_q;
  data_t s0_x_q, s0_y_q, s0_z_q;

  // Stage 1: squares.
  logic                 s1_v_q;
  data_t                s1_x_q, s1_y_q, s1_z_q;
  logic signed [PW-1:0] s1_xx_q, s1_yy_q, s1_zz_q;

  // Stage 2: sum of squares.
  logic          s2_v_q;
  data_t         s2_x_q, s2_y_q, s2_z_q;
  logic [PW-1:0] s2_sum_q;

  // Square root stages; index 0 holds the radicand.
  logic              sq_v_q    [ROOT_W+1];
  logic [RAD_W-1:0]  sq_rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0] sq_root_q [ROOT_W+1];
  logic              sq_bad_q  [ROOT_W+1];
  data_t             sq_x_q    [ROOT_W+1];
  data_t             sq_y_q    [ROOT_W+1];
  data_t             sq_z_q    [ROOT_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q    <= 1'b0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      sq_v_q[0] <= 1'b0;
    end else if (adv) begin
      s0_v_q    <= in_i.valid;
      s1_v_q    <= s0_v_q;
      s2_v_q    <= s1_v_q;
      sq_v_q[0] <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_x_q   <= in_i.vec_x;
      s0_y_q   <= in_i.vec_y;
      s0_z_q   <= in_i.vec_z;
      s1_x_q   <= s0_x_q;
      s1_y_q   <= s0_y_q;
      s1_z_q   <= s0_z_q;
      s1_xx_q  <= PW'(s0_x_q) * PW'(s0_x_q);
      s1_yy_q  <= PW'(s0_y_q) * PW'(s0_y_q);
      s1_zz_q  <= PW'(s0_z_q) * PW'(s0_z_q);
      s2_x_q   <= s1_x_q;
      s2_y_q   <= s1_y_q;
      s2_z_q   <= s1_z_q;
      s2_sum_q <= $unsigned(s1_xx_q) + $unsigned(s1_yy_q) + $unsigned(s1_zz_q);
      sq_x_q[0]    <= s2_x_q;
      sq_y_q[0]    <= s2_y_q;
      sq_z_q[0]    <= s2_z_q;
      sq_bad_q[0]  <= s2_sum_q > ONE;
      sq_rem_q[0]  <= (s2_sum_q > ONE) ? '0 : RAD_W'(ONE - s2_sum_q);
      sq_root_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    localparam int unsigned B = ROOT_W - 1 - k;
    logic [TW-1:0]     trial;
    logic              take;
    logic [RAD_W-1:0]  rem_d;
    logic [ROOT_W-1:0] root_d;

    always_comb begin
      trial  = (TW'(sq_root_q[k]) << (B + 1)) + (TW'(1) << (2 * B));
      take   = TW'(sq_rem_q[k]) >= trial;
      rem_d  = take ? RAD_W'(TW'(sq_rem_q[k]) - trial) : sq_rem_q[k];
      root_d = take ? (sq_root_q[k] | (ROOT_W'(1) << B)) : sq_root_q[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_rem_q[k+1]  <= rem_d;
        sq_root_q[k+1] <= root_d;
        sq_bad_q[k+1]  <= sq_bad_q[k];
        sq_x_q[k+1]    <= sq_x_q[k];
        sq_y_q[k+1]    <= sq_y_q[k];
        sq_z_q[k+1]    <= sq_z_q[k];
      end
    end
  end

  // Stage 4: all products.
  logic                   ws;
  logic signed [ROOT_W:0] w_s;
  data_t                  fx, fy, fz;
  assign w_s = $signed({1'b0, sq_root_q[ROOT_W]});
  assign ws  = sq_v_q[ROOT_W];
  assign fx  = sq_x_q[ROOT_W];
  assign fy  = sq_y_q[ROOT_W];
  assign fz  = sq_z_q[ROOT_W];

  logic                 s4_v_q, s4_bad_q;
  logic [ROOT_W-1:0]    s4_w_q;
  logic signed [PW-1:0] s4_ww_q, s4_xx_q, s4_yy_q, s4_zz_q;
  logic signed [PW-1:0] s4_xy_q, s4_xz_q, s4_yz_q, s4_wx_q, s4_wy_q, s4_wz_q;

  // Stage 5: partial sums and off-diagonal sums.
  logic                 s5_v_q, s5_bad_q;
  logic [ROOT_W-1:0]    s5_w_q;
  logic signed [SW-1:0] s5_p_q, s5_q_q, s5_r_q, s5_s_q;
  logic signed [SW-1:0] s5_m01_q, s5_m02_q, s5_m10_q, s5_m12_q, s5_m20_q, s5_m21_q;

  // Stage 6: diagonal sums.
  logic                 s6_v_q, s6_bad_q;
  logic [ROOT_W-1:0]    s6_w_q;
  logic signed [SW-1:0] s6_m00_q, s6_m11_q, s6_m22_q;
  logic signed [SW-1:0] s6_m01_q, s6_m02_q, s6_m10_q, s6_m12_q, s6_m20_q, s6_m21_q;

  // Stage 7: rounded, saturated output register.
  data_t   o_m00_q, o_m01_q, o_m02_q, o_m10_q, o_m11_q, o_m12_q, o_m20_q, o_m21_q, o_m22_q;
  scalar_t o_w_q;
  logic    o_bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      s6_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s4_v_q  <= ws;
      s5_v_q  <= s4_v_q;
      s6_v_q  <= s5_v_q;
      out_v_q <= s6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_bad_q <= sq_bad_q[ROOT_W];
      s4_w_q   <= sq_root_q[ROOT_W];
      s4_ww_q  <= PW'(w_s) * PW'(w_s);
      s4_xx_q  <= PW'(fx) * PW'(fx);
      s4_yy_q  <= PW'(fy) * PW'(fy);
      s4_zz_q  <= PW'(fz) * PW'(fz);
      s4_xy_q  <= PW'(fx) * PW'(fy);
      s4_xz_q  <= PW'(fx) * PW'(fz);
      s4_yz_q  <= PW'(fy) * PW'(fz);
      s4_wx_q  <= PW'(w_s) * PW'(fx);
      s4_wy_q  <= PW'(w_s) * PW'(fy);
      s4_wz_q  <= PW'(w_s) * PW'(fz);

      s5_bad_q <= s4_bad_q;
      s5_w_q   <= s4_w_q;
      s5_p_q   <= SW'(s4_ww_q) - SW'(s4_zz_q);
      s5_q_q   <= SW'(s4_xx_q) - SW'(s4_yy_q);
      s5_r_q   <= SW'(s4_ww_q) + SW'(s4_zz_q);
      s5_s_q   <= SW'(s4_xx_q) + SW'(s4_yy_q);
      s5_m01_q <= SW'(s4_xy_q) + SW'(s4_wz_q);
      s5_m02_q <= SW'(s4_xz_q) - SW'(s4_wy_q);
      s5_m10_q <= SW'(s4_xy_q) - SW'(s4_wz_q);
      s5_m12_q <= SW'(s4_yz_q) + SW'(s4_wx_q);
      s5_m20_q <= SW'(s4_xz_q) + SW'(s4_wy_q);
      s5_m21_q <= SW'(s4_yz_q) - SW'(s4_wx_q);

      s6_bad_q <= s5_bad_q;
      s6_w_q   <= s5_w_q;
      s6_m00_q <= s5_p_q + s5_q_q;
      s6_m11_q <= s5_p_q - s5_q_q;
      s6_m22_q <= s5_r_q - s5_s_q;
      s6_m01_q <= s5_m01_q;
      s6_m02_q <= s5_m02_q;
      s6_m10_q <= s5_m10_q;
      s6_m12_q <= s5_m12_q;
      s6_m20_q <= s5_m20_q;
      s6_m21_q <= s5_m21_q;

      o_m00_q <= round_sat(s6_m00_q, FRAC_BITS);
      o_m11_q <= round_sat(s6_m11_q, FRAC_BITS);
      o_m22_q <= round_sat(s6_m22_q, FRAC_BITS);
      o_m01_q <= round_sat(s6_m01_q, FRAC_BITS - 1);
      o_m02_q <= round_sat(s6_m02_q, FRAC_BITS - 1);
      o_m10_q <= round_sat(s6_m10_q, FRAC_BITS - 1);
      o_m12_q <= round_sat(s6_m12_q, FRAC_BITS - 1);
      o_m20_q <= round_sat(s6_m20_q, FRAC_BITS - 1);
      o_m21_q <= round_sat(s6_m21_q, FRAC_BITS - 1);
      o_w_q   <= SCALAR_W'(s6_w_q);
      o_bad_q <= s6_bad_q;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.row0_col0    = o_m00_q;
  assign out_o.row0_col1    = o_m01_q;
  assign out_o.row0_col2    = o_m02_q;
  assign out_o.row1_col0    = o_m10_q;
  assign out_o.row1_col1    = o_m11_q;
  assign out_o.row1_col2    = o_m12_q;
  assign out_o.row2_col0    = o_m20_q;
  assign out_o.row2_col1    = o_m21_q;
  assign out_o.row2_col2    = o_m22_q;
  assign out_o.scalar_part  = o_w_q;
  assign out_o.norm_invalid = o_bad_q;

`ifndef NO_ASSERTIONS
  a_bad_zero_w: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.norm_invalid |-> out_o.scalar_part == '0)
    else $error("scalar part not clamped on norm overflow");

  a_w_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.scalar_part <= (SCALAR_W'(1) << FRAC_BITS))
    else $error("scalar part above one");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("input accepted while output stalled");

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(s6_v_q))
    else $error("pipeline moved during stall");
`endif

endmodule

[bench/quaternion_to_rotation_matrix_core_tb.sv]
// Self-checking testbench for the quaternion to rotation matrix core with random stalls.
module quaternion_to_rotation_matrix_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qrm_pkg::*;

  localparam int unsigned FB = FRAC_BITS_DEF;

  typedef struct packed {
    data_t [8:0] elem;
    scalar_t     scalar;
    logic        bad;
  } dcm_t;

  logic clk_i;
  logic rst_ni;

  qrm_in_if  in_if();
  qrm_out_if out_if();

  quaternion_to_rotation_matrix_core #(.FRAC_BITS(FB)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  dcm_t dcm_queue[$];
  int   error_count = 0;
  int   src_idle_pct = 0;
  int   sink_stall_pct = 0;
  int   hold_req = 0;
  int   hold_left = 0;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic data_t round_clamp(logic [63:0] u, int sh);
    logic [63:0]        r;
    logic signed [63:0] q;
    r = u + (64'd1 << (sh - 1));
    q = $signed(r) >>> sh;
    if (q > 64'sd2147483647) return 32'h7fff_ffff;
    if (q < -64'sd2147483648) return 32'h8000_0000;
    return q[31:0];
  endfunction

  function automatic dcm_t predict_dcm(data_t vx, data_t vy, data_t vz);
    dcm_t        d;
    longint      x;
    longint      y;
    longint      z;
    longint      ws;
    logic [63:0] xx;
    logic [63:0] yy;
    logic [63:0] zz;
    logic [63:0] ww;
    logic [63:0] sum;
    logic [63:0] one;
    logic [63:0] w;
    x = vx;
    y = vy;
    z = vz;
    xx = x * x;
    yy = y * y;
    zz = z * z;
    sum = xx + yy + zz;
    one = 64'd1 << (2 * FB);
    d.bad = sum > one;
    w = d.bad ? 64'd0 : floor_sqrt(one - sum);
    ws = w;
    ww = w * w;
    d.elem[0] = round_clamp(ww + xx - yy - zz, FB);
    d.elem[1] = round_clamp(x * y + ws * z, FB - 1);
    d.elem[2] = round_clamp(x * z - ws * y, FB - 1);
    d.elem[3] = round_clamp(x * y - ws * z, FB - 1);
    d.elem[4] = round_clamp(ww - xx + yy - zz, FB);
    d.elem[5] = round_clamp(y * z + ws * x, FB - 1);
    d.elem[6] = round_clamp(x * z + ws * y, FB - 1);
    d.elem[7] = round_clamp(y * z - ws * x, FB - 1);
    d.elem[8] = round_clamp(ww - xx - yy + zz, FB);
    d.scalar = w[SCALAR_W-1:0];
    return d;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("Mismatch in %s: got %h, expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    dcm_t got;
    dcm_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.elem = {out_if.row2_col2, out_if.row2_col1, out_if.row2_col0,
                  out_if.row1_col2, out_if.row1_col1, out_if.row1_col0,
                  out_if.row0_col2, out_if.row0_col1, out_if.row0_col0};
      got.scalar = out_if.scalar_part;
      got.bad = out_if.norm_invalid;
      if (dcm_queue.size() == 0) begin
        $display("Unexpected output transaction at %0t", $realtime);
        error_count++;
      end else begin
        want = dcm_queue.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (got.elem[i] !== want.elem[i]) begin
            report_mismatch($sformatf("row%0d_col%0d", i / 3, i % 3), got.elem[i], want.elem[i]);
          end
        end
        if (got.scalar !== want.scalar) begin
          report_mismatch("scalar_part", 32'(got.scalar), 32'(want.scalar));
        end
        if (got.bad !== want.bad) begin
          report_mismatch("norm_invalid", 32'(got.bad), 32'(want.bad));
        end
      end
    end
  end

  task automatic send_quat(data_t vx, data_t vy, data_t vz);
    in_if.valid <= 1'b1;
    in_if.vec_x <= vx;
    in_if.vec_y <= vy;
    in_if.vec_z <= vz;
    do @(posedge clk_i); while (!in_if.ready);
    dcm_queue.push_back(predict_dcm(vx, vy, vz));
    if ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
  endtask

  task automatic drain;
    in_if.valid <= 1'b0;
    while (dcm_queue.size() != 0) @(posedge clk_i);
    repeat (FB + 20) @(posedge clk_i);
  endtask

  function automatic data_t unit_comp();
    return data_t'(int'($urandom_range(0, 1 << 30)) - (1 << 29));
  endfunction

  task automatic test_directed;
    data_t one_q;
    one_q = data_t'(1 << FB);
    send_quat(0, 0, 0);
    send_quat(one_q, 0, 0);
    send_quat(0, one_q, 0);
    send_quat(0, 0, -one_q);
    send_quat(-one_q, 0, 0);
    send_quat(one_q, 1, 0);
    send_quat(one_q, one_q, one_q);
    send_quat(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_quat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_quat(32'h8000_0000, 32'h7fff_ffff, 0);
    send_quat(32'h7fff_ffff, 0, 32'h8000_0000);
    send_quat(data_t'(1 << 29), data_t'(1 << 29), data_t'(1 << 29));
    send_quat(-data_t'(1 << 29), data_t'(1 << 29), -data_t'(1 << 29));
    send_quat(1, -1, 1);
    send_quat(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_quat(data_t'(759250125), data_t'(759250125), 0);
    send_quat(data_t'(759250124), data_t'(759250124), 0);
    send_quat(32'h5555_5555, 32'haaaa_aaaa, 32'h3333_3333);
    drain();
  endtask

  task automatic test_random(int n, int idle, int stall);
    src_idle_pct = idle;
    sink_stall_pct = stall;
    repeat (n) begin
      if ($urandom_range(99) < 75) begin
        send_quat(unit_comp(), unit_comp(), unit_comp());
      end else begin
        send_quat($urandom, $urandom, $urandom);
      end
    end
    drain();
  endtask

  task automatic test_backpressure;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_req = 200;
    repeat (120) send_quat(unit_comp(), unit_comp(), unit_comp());
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.vec_x = '0;
    in_if.vec_y = '0;
    in_if.vec_z = '0;
    out_if.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(180, 0, 0);
    test_random(180, 64, 0);
    test_random(180, 0, 64);
    test_random(180, 25, 25);
    test_backpressure();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[sim.f]
rtl/core/qrm_pkg.sv
rtl/core/qrm_if.sv
rtl/core/quaternion_to_rotation_matrix_core.sv
bench/quaternion_to_rotation_matrix_core_tb.sv
